// ----- rtl/fts_pkg.sv -----
// Shared types and constants for the fan tachometer speed meter.
// Holds the controller state type, the command and status structs and the
// register indexes. Depends on nothing.
`default_nettype none

package fts_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_PERIOD   = 8'd3;

    // Register reset values.
    localparam logic [31:0] RST_SPEED_GAIN    = 32'd0;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd100;
    localparam logic [4:0]  RST_AVG_LEN       = 5'd4;
    localparam logic [15:0] RST_WRAP_PERIOD   = 16'hFFFF;

    // Saturation value of a 16-bit speed.
    localparam logic [15:0] SPEED_SAT = 16'hFFFF;

    // Divider geometry: gain over period.
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;

    // Input item codes.
    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SPD_START,
        ST_SPD_WAIT,
        ST_RING,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the accepted input item
        logic eval;         // apply timeout, stamp and period updates
        logic spd_start;    // start gain / period, or saturate on zero period
        logic load_raw;     // take the raw speed from the divider
        logic ring_update;  // insert the raw speed into the ring
        logic avg_start;    // start ring_sum / ring_filled
        logic load_speed;   // take the averaged speed from the divider
        logic load_out;     // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic measure;      // the held item is a capture that yields a period
        logic period_zero;  // the computed period is zero
        logic div_done;     // the divider finished this cycle
        logic out_free;     // the output register can take a result
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/fan_tach_speed_meter.sv -----
// Fan tachometer speed meter, top level.
// Input items are tach capture timestamps (mode 0) or 10 ms ticks (mode 1).
// Each item gives exactly one result: averaged speed, last period, an update
// flag and a timed-out flag. A capture after the first one measures the period,
// divides speed_gain by it and feeds the quotient into a moving average.
// A tick or a capture that makes no speed sample goes from evaluation straight
// to the result. A capture with a zero period skips the speed division. A
// measuring capture waits twice on the shared radix-4 divider, first for the
// speed quotient, then for the average quotient.
// One item is in work at a time; the next item is accepted as soon as the
// controller is back in idle, even while the previous result still waits.
// Configuration writes on the cfg channel are always ready and take effect at
// once; write them only while the block is idle.
// Reset (synchronous, active low) restores the register defaults and clears
// the capture state, the timeout counter and the averaging ring.
// A stall on the result channel holds the output register; the block then
// finishes the next item and waits with it until the register is free.
// Depends on fts_pkg, fts_ctrl, fts_datapath and fts_div.
`default_nettype none

module fan_tach_speed_meter #(
    parameter int AVG_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Item input channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_mode,
    input  wire logic [15:0]                    i_capture_time,
    // Result output channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [15:0]                         o_speed,
    output logic [15:0]                         o_last_period,
    output logic                                o_speed_updated,
    output logic                                o_timed_out,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fts_pkg::t_cmd    cmd;
    fts_pkg::t_status status;
    logic             in_ready;

    fts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    fts_datapath #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_capture_time  (i_capture_time),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_speed         (o_speed),
        .o_last_period   (o_last_period),
        .o_speed_updated (o_speed_updated),
        .o_timed_out     (o_timed_out)
    );

    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = 1'b1;

    // A new speed sample never comes with a timeout.
    a_upd_not_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speed_updated) |-> !o_timed_out)
        else $error("speed update reported together with a timeout");

    // A timed-out result reports cleared speed and period.
    a_timeout_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |-> (o_speed == 16'd0 && o_last_period == 16'd0))
        else $error("timed-out result carries a stale speed or period");

    // An accepted transaction keeps the input stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again while an item is in work");

endmodule

`default_nettype wire

// ----- rtl/fts_div.sv -----
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Used for both the speed quotient and the moving-average quotient.
// Depends on nothing; NUM_W must be even.
`default_nettype none

module fts_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0] r_work, n_work;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    // Two dependent restoring steps per cycle.
    always_comb begin
        logic [DEN_W:0] sh;
        n_rem  = r_rem;
        n_work = r_work;
        for (int k = 0; k < 2; k++) begin
            sh = {n_rem, n_work[NUM_W-1]};
            if (sh >= {1'b0, r_den}) begin
                sh     = sh - {1'b0, r_den};
                n_work = {n_work[NUM_W-2:0], 1'b1};
            end else begin
                n_work = {n_work[NUM_W-2:0], 1'b0};
            end
            n_rem = sh[DEN_W-1:0];
        end
    end

    // Iteration counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers: the numerator shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

`default_nettype wire

// ----- rtl/fts_ctrl.sv -----
// Controller state machine of the fan tachometer speed meter.
// Sequences each item through evaluation, up to two divisions and the result.
// Depends on fts_pkg.
`default_nettype none

module fts_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire fts_pkg::t_status i_status,
    output fts_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready
);

    fts_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = fts_pkg::ST_EVAL;
                end
            end
            fts_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.measure ? fts_pkg::ST_SPD_START : fts_pkg::ST_FINISH;
            end
            fts_pkg::ST_SPD_START: begin
                o_cmd.spd_start = 1'b1;
                n_state = i_status.period_zero ? fts_pkg::ST_RING : fts_pkg::ST_SPD_WAIT;
            end
            fts_pkg::ST_SPD_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.load_raw = 1'b1;
                    n_state        = fts_pkg::ST_RING;
                end
            end
            fts_pkg::ST_RING: begin
                o_cmd.ring_update = 1'b1;
                n_state           = fts_pkg::ST_AVG_START;
            end
            fts_pkg::ST_AVG_START: begin
                o_cmd.avg_start = 1'b1;
                n_state         = fts_pkg::ST_AVG_WAIT;
            end
            fts_pkg::ST_AVG_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.load_speed = 1'b1;
                    n_state          = fts_pkg::ST_FINISH;
                end
            end
            fts_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = fts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fts_datapath.sv -----
// Datapath of the fan tachometer speed meter: configuration registers,
// capture state, averaging ring, shared divider and output register.
// Depends on fts_pkg and fts_div.
`default_nettype none

module fts_datapath #(
    parameter int AVG_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fts_pkg::t_cmd                  i_cmd,
    output fts_pkg::t_status                    o_status,
    input  wire logic                           i_mode,
    input  wire logic [15:0]                    i_capture_time,
    input  wire logic                           i_cfg_valid,
    input  wire logic [fts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic [15:0]                         o_speed,
    output logic [15:0]                         o_last_period,
    output logic                                o_speed_updated,
    output logic                                o_timed_out
);

    localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W  = 16 + FILL_W;
    localparam int CMP_W  = ((FILL_W > 5) ? FILL_W : 5) + 1;
    localparam int NUM_W  = fts_pkg::DIV_NUM_W;
    localparam int DEN_W  = fts_pkg::DIV_DEN_W;

    // Configuration registers.
    logic [31:0] r_speed_gain;
    logic [15:0] r_timeout_ticks;
    logic [4:0]  r_avg_len;
    logic [15:0] r_wrap_period;

    // Measurement state.
    logic             r_mode;
    logic [15:0]      r_stamp;
    logic [15:0]      r_prev_stamp;
    logic [1:0]       r_capture_seen;
    logic [15:0]      r_timeout_left;
    logic [15:0]      r_ring [AVG_DEPTH];
    logic [POS_W-1:0] r_ring_pos;
    logic [FILL_W-1:0] r_ring_filled;
    logic [SUM_W-1:0] r_ring_sum;
    logic [15:0]      r_speed;
    logic [15:0]      r_period;
    logic [15:0]      r_raw;
    logic             r_updated;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_speed;
    logic [15:0] r_out_period;
    logic        r_out_updated;
    logic        r_out_timed_out;

    // Combinational helpers.
    logic [15:0]      period_calc;
    logic             clear_now;
    logic [CMP_W-1:0] win;
    logic [CMP_W-1:0] pos_eff;
    logic [CMP_W-1:0] pos_inc;
    logic [CMP_W-1:0] filled_inc;
    logic [POS_W-1:0] ring_idx;
    logic [POS_W-1:0] n_ring_pos;
    logic [FILL_W-1:0] n_ring_filled;
    logic [SUM_W-1:0] n_ring_sum;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [15:0]      quot_sat;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain    <= fts_pkg::RST_SPEED_GAIN;
            r_timeout_ticks <= fts_pkg::RST_TIMEOUT_TICKS;
            r_avg_len       <= fts_pkg::RST_AVG_LEN;
            r_wrap_period   <= fts_pkg::RST_WRAP_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fts_pkg::CFG_SPEED_GAIN:    r_speed_gain    <= i_cfg_data;
                fts_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                fts_pkg::CFG_AVG_LEN:       r_avg_len       <= i_cfg_data[4:0];
                fts_pkg::CFG_WRAP_PERIOD:   r_wrap_period   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Period between captures, with the wrap correction when the new stamp is not above the last one.
    always_comb begin
        period_calc = r_stamp - r_prev_stamp;
        if (r_stamp <= r_prev_stamp) begin
            period_calc = period_calc + r_wrap_period;
        end
    end

    // The measurement is cleared whenever the timeout counter ends at zero.
    assign clear_now = (r_mode == fts_pkg::MODE_TICK) ? (r_timeout_left <= 16'd1)
                                                      : (r_timeout_ticks == 16'd0);

    // Effective window length, ring position and fill count.
    always_comb begin
        if (r_avg_len == 5'd0) begin
            win = CMP_W'(1);
        end else if (CMP_W'(r_avg_len) > CMP_W'(AVG_DEPTH)) begin
            win = CMP_W'(AVG_DEPTH);
        end else begin
            win = CMP_W'(r_avg_len);
        end
        pos_eff       = (CMP_W'(r_ring_pos) >= win) ? '0 : CMP_W'(r_ring_pos);
        pos_inc       = pos_eff + 1'b1;
        filled_inc    = CMP_W'(r_ring_filled) + 1'b1;
        ring_idx      = pos_eff[POS_W-1:0];
        n_ring_pos    = (pos_inc >= win) ? '0 : pos_inc[POS_W-1:0];
        n_ring_filled = (filled_inc > win) ? win[FILL_W-1:0] : filled_inc[FILL_W-1:0];
        n_ring_sum    = r_ring_sum - SUM_W'(r_ring[ring_idx]) + SUM_W'(r_raw);
    end

    // Shared divider: gain over period, then ring sum over fill count.
    assign div_start = (i_cmd.spd_start && (r_period != 16'd0)) || i_cmd.avg_start;
    assign div_num   = i_cmd.avg_start ? NUM_W'(r_ring_sum) : r_speed_gain;
    assign div_den   = i_cmd.avg_start ? DEN_W'(r_ring_filled) : r_period;

    fts_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign quot_sat = (div_quot[NUM_W-1:16] != '0) ? fts_pkg::SPEED_SAT : div_quot[15:0];

    // Input item holding register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_mode;
            r_stamp <= i_capture_time;
        end
    end

    // Raw speed, zero period saturates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.spd_start && (r_period == 16'd0)) begin
            r_raw <= fts_pkg::SPEED_SAT;
        end else if (i_cmd.load_raw) begin
            r_raw <= quot_sat;
        end
    end

    // Capture state, timeout, averaging ring and speed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp   <= '0;
            r_capture_seen <= '0;
            r_timeout_left <= '0;
            r_ring_pos     <= '0;
            r_ring_filled  <= '0;
            r_ring_sum     <= '0;
            r_speed        <= '0;
            r_period       <= '0;
            r_updated      <= 1'b0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_cmd.eval) begin
            r_updated <= 1'b0;
            if (r_mode == fts_pkg::MODE_CAPTURE) begin
                r_timeout_left <= r_timeout_ticks;
                if (r_timeout_ticks != 16'd0) begin
                    r_prev_stamp <= r_stamp;
                    if (r_capture_seen != 2'd0) begin
                        r_capture_seen <= 2'd2;
                        r_period       <= period_calc;
                    end else begin
                        r_capture_seen <= 2'd1;
                    end
                end
            end else if (r_timeout_left != 16'd0) begin
                r_timeout_left <= r_timeout_left - 1'b1;
            end
            if (clear_now) begin
                r_capture_seen <= '0;
                r_ring_pos     <= '0;
                r_ring_filled  <= '0;
                r_ring_sum     <= '0;
                r_speed        <= '0;
                r_period       <= '0;
                for (int i = 0; i < AVG_DEPTH; i++) begin
                    r_ring[i] <= '0;
                end
            end
        end else if (i_cmd.ring_update) begin
            r_ring[ring_idx] <= r_raw;
            r_ring_pos       <= n_ring_pos;
            r_ring_filled    <= n_ring_filled;
            r_ring_sum       <= n_ring_sum;
        end else if (i_cmd.load_speed) begin
            r_speed   <= quot_sat;
            r_updated <= 1'b1;
        end
    end

    // Output register: holds while stalled, takes a new result when free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_speed     <= r_speed;
            r_out_period    <= r_period;
            r_out_updated   <= r_updated;
            r_out_timed_out <= (r_timeout_left == 16'd0);
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.measure     = (r_mode == fts_pkg::MODE_CAPTURE) &&
                               (r_timeout_ticks != 16'd0) && (r_capture_seen != 2'd0);
        o_status.period_zero = (r_period == 16'd0);
        o_status.div_done    = div_done;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed         = r_out_speed;
    assign o_last_period   = r_out_period;
    assign o_speed_updated = r_out_updated;
    assign o_timed_out     = r_out_timed_out;

    // The fill count never exceeds the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_ring_filled) <= CMP_W'(AVG_DEPTH))
        else $error("ring fill count exceeds the ring depth");

    // A nonzero fill count implies that two or more captures were seen.
    a_fill_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring_filled != '0) |-> (r_capture_seen == 2'd2))
        else $error("ring holds samples without a measured period");

endmodule

`default_nettype wire

// ----- test/fts_checker.sv -----
// Result checker for the fan tachometer speed meter testbench.
// Watches the item, result and configuration channels, predicts every result
// and compares it field by field. Depends on fts_pkg.
`timescale 1ns / 1ps

module fts_checker #(
    parameter int AVG_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_mode,
    input  logic [15:0]                    i_capture_time,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [15:0]                    i_speed,
    input  logic [15:0]                    i_last_period,
    input  logic                           i_speed_updated,
    input  logic                           i_timed_out,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned                    o_fail_count,
    output int unsigned                    o_pending
);

    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] last_period;
        logic        speed_updated;
        logic        timed_out;
    } t_meter_result;

    // Register copies.
    logic [31:0] gain_q;
    logic [15:0] timeout_reload;
    logic [4:0]  window_cfg;
    logic [15:0] wrap_add;

    // Measurement state.
    logic [15:0] last_stamp;
    logic [1:0]  captures;
    logic [15:0] ticks_left;
    logic [15:0] ring [AVG_DEPTH];
    int unsigned ring_slot;
    int unsigned ring_count;
    int unsigned ring_total;
    logic [15:0] avg_speed;
    logic [15:0] period_now;

    // Results still owed by the block, oldest first.
    t_meter_result owed_results[$];

    initial o_fail_count = 0;

    // Forget every capture and the whole averaging window.
    function automatic void drop_measurement();
        captures   = 2'd0;
        foreach (ring[k]) ring[k] = 16'd0;
        ring_slot  = 0;
        ring_count = 0;
        ring_total = 0;
        avg_speed  = 16'd0;
        period_now = 16'd0;
    endfunction

    // Advance the meter by one item and return the result it must report.
    function automatic t_meter_result meter_step(input logic mode, input logic [15:0] stamp);
        t_meter_result res;
        logic [15:0]   period;
        logic [31:0]   raw;
        int unsigned   win;
        int unsigned   slot;
        int unsigned   quo;
        res.speed_updated = 1'b0;
        if (mode == fts_pkg::MODE_CAPTURE) begin
            ticks_left = timeout_reload;
            if (ticks_left != 16'd0) begin
                if (captures != 2'd0) begin
                    // The period wraps at 16 bits; a stamp not above the last adds the wrap period.
                    period = stamp - last_stamp;
                    if (stamp <= last_stamp) period = period + wrap_add;
                    if (period == 16'd0) begin
                        raw = 32'(fts_pkg::SPEED_SAT);
                    end else begin
                        raw = gain_q / period;
                        if (raw > 32'(fts_pkg::SPEED_SAT)) raw = 32'(fts_pkg::SPEED_SAT);
                    end
                    period_now = period;
                    // Insert into the ring; a shrunk window restarts the write slot.
                    win = (window_cfg == 5'd0) ? 1 :
                          ((window_cfg > AVG_DEPTH) ? AVG_DEPTH : window_cfg);
                    slot = (ring_slot >= win) ? 0 : ring_slot;
                    ring_total = ring_total - ring[slot] + raw[15:0];
                    ring[slot] = raw[15:0];
                    ring_slot  = (slot + 1 >= win) ? 0 : slot + 1;
                    ring_count = (ring_count + 1 > win) ? win : ring_count + 1;
                    quo = ring_total / ring_count;
                    avg_speed = (quo > fts_pkg::SPEED_SAT) ? fts_pkg::SPEED_SAT : quo[15:0];
                    res.speed_updated = 1'b1;
                    captures = 2'd2;
                end else begin
                    captures = 2'd1;
                end
                last_stamp = stamp;
            end
        end else if (ticks_left != 16'd0) begin
            ticks_left = ticks_left - 16'd1;
        end
        if (ticks_left == 16'd0) drop_measurement();
        res.speed       = avg_speed;
        res.last_period = period_now;
        res.timed_out   = (ticks_left == 16'd0);
        return res;
    endfunction

    // Report one field that differs from its prediction.
    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Everything is sampled at the rising edge, where the block samples too.
    always @(posedge i_clk) begin : watch
        t_meter_result want;
        if (!i_rst_n) begin
            gain_q         = fts_pkg::RST_SPEED_GAIN;
            timeout_reload = fts_pkg::RST_TIMEOUT_TICKS;
            window_cfg     = fts_pkg::RST_AVG_LEN;
            wrap_add       = fts_pkg::RST_WRAP_PERIOD;
            last_stamp     = 16'd0;
            ticks_left     = 16'd0;
            drop_measurement();
            owed_results.delete();
        end else begin
            // A result transaction is matched against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with none expected: speed %0d, period %0d",
                           i_speed, i_last_period);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("speed", want.speed, i_speed);
                    check_field("last_period", want.last_period, i_last_period);
                    check_field("speed_updated", want.speed_updated, i_speed_updated);
                    check_field("timed_out", want.timed_out, i_timed_out);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(meter_step(i_mode, i_capture_time));
            end
            // Register writes; an unknown index leaves everything as it was.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fts_pkg::CFG_SPEED_GAIN:    gain_q         = i_cfg_data;
                    fts_pkg::CFG_TIMEOUT_TICKS: timeout_reload = i_cfg_data[15:0];
                    fts_pkg::CFG_AVG_LEN:       window_cfg     = i_cfg_data[4:0];
                    fts_pkg::CFG_WRAP_PERIOD:   wrap_add       = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_pending <= owed_results.size();
    end

endmodule

// ----- test/testbench.sv -----
// Top of the fan tachometer speed meter testbench.
// Drives captures, ticks and register writes with random idling and gives the
// verdict. Depends on fts_pkg, fan_tach_speed_meter and fts_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF       = 5;
    localparam int AVG_DEPTH      = 16;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 19;
    localparam int PHASE_ITEMS    = 100;
    localparam logic [fts_pkg::CFG_IDX_W-1:0] CFG_NO_SUCH_REG =
        fts_pkg::CFG_WRAP_PERIOD + 1'b1;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_mode   = fts_pkg::MODE_CAPTURE;
    logic [15:0]                    in_time   = 16'd0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [fts_pkg::CFG_IDX_W-1:0]  cfg_index = fts_pkg::CFG_SPEED_GAIN;
    logic [fts_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    wire                   in_stall;
    wire                   out_valid;
    wire  [15:0]           speed;
    wire  [15:0]           last_period;
    wire                   speed_updated;
    wire                   timed_out;
    wire                   cfg_ready;
    wire  [31:0]           fail_count;
    wire  [31:0]           pending;

    // Shared between the sender and the receiver.
    bit                    no_idle       = 1'b0;
    bit                    long_hold_req = 1'b0;
    logic [15:0]           run_stamp     = 16'd0;
    int unsigned           quiet_cycles  = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    fan_tach_speed_meter #(.AVG_DEPTH(AVG_DEPTH)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (in_mode),
        .i_capture_time  (in_time),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_speed         (speed),
        .o_last_period   (last_period),
        .o_speed_updated (speed_updated),
        .o_timed_out     (timed_out),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    fts_checker #(.AVG_DEPTH(AVG_DEPTH)) result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (in_mode),
        .i_capture_time  (in_time),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_speed         (speed),
        .i_last_period   (last_period),
        .i_speed_updated (speed_updated),
        .i_timed_out     (timed_out),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(21, 120);
    endfunction

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(input logic mode, input logic [15:0] stamp);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_time  <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // One register write transaction; valid drops for a cycle afterwards.
    task automatic write_reg(input logic [fts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fts_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, wait for every owed result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register settings for one random phase; the first two are the extremes.
    task automatic random_config(input int unsigned ph);
        logic [31:0] gain;
        logic [15:0] reload;
        logic [4:0]  win;
        logic [15:0] wrap;
        int unsigned r;
        if (ph == 0) begin
            gain = 32'hFFFF_FFFF; reload = 16'hFFFF; win = 5'(AVG_DEPTH); wrap = 16'hFFFF;
        end else if (ph == 1) begin
            gain = 32'd0; reload = 16'd0; win = 5'd1; wrap = 16'd1;
        end else begin
            r = $urandom_range(0, 3);
            if (r == 0)      gain = $urandom;
            else if (r == 1) gain = $urandom_range(1, 32'h0010_0000);
            else if (r == 2) gain = $urandom_range(0, 300);
            else             gain = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
            r = $urandom_range(0, 15);
            if (r == 0)      reload = 16'd0;
            else if (r < 5)  reload = 16'($urandom_range(1, 5));
            else if (r < 14) reload = 16'($urandom_range(6, 300));
            else             reload = 16'hFFFF;
            win  = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, AVG_DEPTH))
                                                : 5'($urandom_range(0, 31));
            r = $urandom_range(0, 3);
            wrap = (r == 0) ? 16'hFFFF : ((r == 1) ? 16'd1 : 16'($urandom_range(1, 65535)));
        end
        write_reg(fts_pkg::CFG_SPEED_GAIN, gain);
        write_reg(fts_pkg::CFG_TIMEOUT_TICKS, {16'd0, reload});
        write_reg(fts_pkg::CFG_AVG_LEN, {27'd0, win});
        write_reg(fts_pkg::CFG_WRAP_PERIOD, {16'd0, wrap});
    endtask

    // Mostly steadily advancing captures, some ticks, some noise.
    task automatic random_item();
        int unsigned r;
        int unsigned s;
        logic [31:0] noise;
        r = $urandom_range(0, 99);
        noise = $urandom;
        if (r < 12) begin
            send_item(fts_pkg::MODE_TICK, noise[15:0]);
        end else begin
            if (r < 80) begin
                s = $urandom_range(0, 9);
                if (s < 4)      run_stamp = run_stamp + 16'($urandom_range(1, 50));
                else if (s < 8) run_stamp = run_stamp + 16'($urandom_range(51, 3000));
                else            run_stamp = run_stamp + 16'($urandom_range(3001, 65535));
            end else if (r < 92) begin
                // Equal or slightly earlier stamp: periods that take the wrap correction.
                run_stamp = run_stamp - 16'($urandom_range(0, 200));
            end else begin
                run_stamp = noise[15:0];
            end
            send_item(fts_pkg::MODE_CAPTURE, run_stamp);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin : receiver
        int unsigned stall_len;
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall_len = pick_gap();
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("fan_tach_speed_meter regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned ph;
        int unsigned k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick before any capture, first capture, plain, zero and wrapped periods.
        write_reg(fts_pkg::CFG_SPEED_GAIN, 32'd1_000_000);
        write_reg(fts_pkg::CFG_WRAP_PERIOD, 32'd100);
        write_reg(fts_pkg::CFG_AVG_LEN, 32'd4);
        send_item(fts_pkg::MODE_TICK, 16'hFFFF);
        send_item(fts_pkg::MODE_CAPTURE, 16'd0);
        send_item(fts_pkg::MODE_CAPTURE, 16'd1000);
        send_item(fts_pkg::MODE_CAPTURE, 16'd900);
        send_item(fts_pkg::MODE_CAPTURE, 16'd900);
        send_item(fts_pkg::MODE_CAPTURE, 16'hFFFF);
        send_item(fts_pkg::MODE_CAPTURE, 16'd0);
        send_item(fts_pkg::MODE_TICK, 16'd0);
        drain();

        // Saturating quotient, timeout by ticks and ticks while timed out.
        write_reg(fts_pkg::CFG_SPEED_GAIN, 32'hFFFF_FFFF);
        write_reg(fts_pkg::CFG_AVG_LEN, 32'd1);
        write_reg(fts_pkg::CFG_TIMEOUT_TICKS, 32'd2);
        send_item(fts_pkg::MODE_CAPTURE, 16'd5);
        send_item(fts_pkg::MODE_CAPTURE, 16'd6);
        send_item(fts_pkg::MODE_TICK, 16'd0);
        send_item(fts_pkg::MODE_TICK, 16'd0);
        send_item(fts_pkg::MODE_TICK, 16'd0);
        send_item(fts_pkg::MODE_CAPTURE, 16'd7);
        drain();

        // Capture with a zero timeout reload and a window length of zero.
        write_reg(fts_pkg::CFG_TIMEOUT_TICKS, 32'd0);
        write_reg(fts_pkg::CFG_AVG_LEN, 32'd0);
        write_reg(fts_pkg::CFG_SPEED_GAIN, 32'd0);
        send_item(fts_pkg::MODE_CAPTURE, 16'd100);
        send_item(fts_pkg::MODE_TICK, 16'd0);
        drain();

        // Oversized window, unknown register, then the window shrinks mid-run.
        write_reg(fts_pkg::CFG_TIMEOUT_TICKS, 32'hFFFF);
        write_reg(fts_pkg::CFG_AVG_LEN, 32'd31);
        write_reg(CFG_NO_SUCH_REG, 32'hFFFF_FFFF);
        write_reg(fts_pkg::CFG_WRAP_PERIOD, 32'd1);
        write_reg(fts_pkg::CFG_SPEED_GAIN, 32'd196_605);
        send_item(fts_pkg::MODE_CAPTURE, 16'd10);
        send_item(fts_pkg::MODE_CAPTURE, 16'd11);
        send_item(fts_pkg::MODE_CAPTURE, 16'd12);
        send_item(fts_pkg::MODE_CAPTURE, 16'd14);
        send_item(fts_pkg::MODE_CAPTURE, 16'd20);
        send_item(fts_pkg::MODE_CAPTURE, 16'd20);
        send_item(fts_pkg::MODE_CAPTURE, 16'd19);
        send_item(fts_pkg::MODE_CAPTURE, 16'd100);
        drain();
        write_reg(fts_pkg::CFG_AVG_LEN, 32'd2);
        send_item(fts_pkg::MODE_CAPTURE, 16'd103);
        drain();

        // Random phases; two of them hold the result side off for a long time.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config(ph);
            no_idle = (ph % 5 == 3) || (ph == 4) || (ph == 12);
            if (ph == 4 || ph == 12) long_hold_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) random_item();
            drain();
        end
        no_idle = 1'b0;

        if (fail_count == 0 && pending == 0) begin
            $display("fan_tach_speed_meter regression: pass");
        end else begin
            $display("fan_tach_speed_meter regression: fail");
        end
        $finish;
    end

endmodule
